/* rtl/qph_pkg.sv */
`default_nettype none

package qph_pkg;

    localparam int MAX_QUARTETS_DEF = 64;
    localparam int OBS_BITS_DEF     = 64;
    localparam int COUNT_BITS_DEF   = 32;

    localparam int CMD_W       = 2;
    localparam int ENTRY_W     = 6;
    localparam int PAT_W       = 4;
    localparam int IDX_W       = 7;
    localparam int OBS_W       = 64;
    localparam int QUARTET_W   = 4 * IDX_W;
    localparam int NUMQ_W      = 7;
    localparam int CNT_OUT_W   = 32;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_NUM_QUARTETS = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_RWAIT,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count_value;
        logic                 saturated;
    } res_t;

endpackage

`default_nettype wire

/* rtl/qph_ram.sv */
`default_nettype none

module qph_ram #(
    parameter int DEPTH = qph_pkg::MAX_QUARTETS_DEF,
    parameter int AW    = 6,
    parameter int DW    = qph_pkg::QUARTET_W
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/qph_ctrl.sv */
`default_nettype none

module qph_ctrl #(
    parameter int MAX_QUARTETS = qph_pkg::MAX_QUARTETS_DEF,
    parameter int OBS_BITS     = qph_pkg::OBS_BITS_DEF,
    parameter int COUNT_BITS   = qph_pkg::COUNT_BITS_DEF,
    localparam int QI_W        = (MAX_QUARTETS > 1) ? $clog2(MAX_QUARTETS) : 1,
    localparam int CA_W        = QI_W + qph_pkg::PAT_W
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input word
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire qph_pkg::cmd_t                  in_cmd,
    input  wire logic [qph_pkg::ENTRY_W-1:0]    in_entry,
    input  wire logic [qph_pkg::PAT_W-1:0]      in_pattern,
    input  wire logic [qph_pkg::QUARTET_W-1:0]  in_quartet,
    input  wire logic [qph_pkg::OBS_W-1:0]      in_obs,
    input  wire logic [qph_pkg::NUMQ_W-1:0]     num_quartets,
    // result handoff
    input  wire logic                           out_free,
    output logic                                done,
    output qph_pkg::res_t                       result,
    // quartet table port
    output logic                                tbl_we,
    output logic [QI_W-1:0]                     tbl_waddr,
    output logic [qph_pkg::QUARTET_W-1:0]       tbl_wdata,
    output logic [QI_W-1:0]                     tbl_raddr,
    input  wire logic [qph_pkg::QUARTET_W-1:0]  tbl_rdata,
    // counter memory port
    output logic                                cnt_we,
    output logic [CA_W-1:0]                     cnt_waddr,
    output logic [COUNT_BITS-1:0]               cnt_wdata,
    output logic [CA_W-1:0]                     cnt_raddr,
    input  wire logic [COUNT_BITS-1:0]          cnt_rdata
);

    localparam int QC_W = $clog2(MAX_QUARTETS + 1);
    localparam int OB_W = $clog2(OBS_BITS);
    localparam logic [CA_W-1:0] LAST_ADDR = CA_W'(MAX_QUARTETS * 16 - 1);

    qph_pkg::state_t state_reg, state_next;

    logic [QI_W-1:0]                entry_reg, entry_next;
    logic [qph_pkg::PAT_W-1:0]      pattern_reg, pattern_next;
    logic                           rd_ok_reg, rd_ok_next;
    logic [OBS_BITS-1:0]            obs_reg, obs_next;
    logic [QC_W-1:0]                active_reg, active_next;
    logic [QC_W-1:0]                issue_idx_reg, issue_idx_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic [QI_W-1:0]                s1_idx_reg, s1_idx_next;
    logic                           s2_valid_reg, s2_valid_next;
    logic [CA_W-1:0]                s2_addr_reg, s2_addr_next;
    logic [CA_W-1:0]                clr_idx_reg, clr_idx_next;
    qph_pkg::res_t                  result_reg, result_next;

    logic                           accept;
    logic                           entry_in_ok;
    logic                           clearing;
    logic                           walk_issue;
    logic                           cnt_full;
    logic [qph_pkg::PAT_W-1:0]      pat_s1;

    function automatic logic [QI_W-1:0] to_qi(input logic [qph_pkg::ENTRY_W-1:0] e);
        logic [QI_W+qph_pkg::ENTRY_W-1:0] w;
        w = {{QI_W{1'b0}}, e};
        return w[QI_W-1:0];
    endfunction

    function automatic logic pick(input logic [qph_pkg::IDX_W-1:0] raw,
                                  input logic [OBS_BITS-1:0] obs);
        logic bit_val;
        bit_val = 1'b0;
        // negative index or an index past the end of the vector reads as zero
        if (!raw[qph_pkg::IDX_W-1] && (32'(raw[qph_pkg::IDX_W-2:0]) < OBS_BITS))
        begin
            bit_val = obs[raw[OB_W-1:0]];
        end
        return bit_val;
    endfunction

    function automatic logic [qph_pkg::CNT_OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] d);
        logic [COUNT_BITS+qph_pkg::CNT_OUT_W-1:0] w;
        w = {{qph_pkg::CNT_OUT_W{1'b0}}, d};
        return w[qph_pkg::CNT_OUT_W-1:0];
    endfunction

    assign accept      = in_valid && in_ready;
    assign entry_in_ok = 32'(in_entry) < MAX_QUARTETS;
    assign clearing    = state_reg inside {qph_pkg::ST_INIT, qph_pkg::ST_CLEAR};
    assign walk_issue  = (state_reg == qph_pkg::ST_WALK) && (issue_idx_reg != active_reg);
    assign cnt_full    = &cnt_rdata;

    // a is the high bit of the pattern
    assign pat_s1 = {pick(tbl_rdata[6:0], obs_reg), pick(tbl_rdata[13:7], obs_reg),
                     pick(tbl_rdata[20:14], obs_reg), pick(tbl_rdata[27:21], obs_reg)};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qph_pkg::ST_INIT:
            begin
                if (clr_idx_reg == LAST_ADDR)
                begin
                    state_next = qph_pkg::ST_IDLE;
                end
            end
            qph_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        qph_pkg::CMD_LOAD:  state_next = qph_pkg::ST_DONE;
                        qph_pkg::CMD_COUNT: state_next = qph_pkg::ST_WALK;
                        qph_pkg::CMD_READ:  state_next = qph_pkg::ST_READ;
                        qph_pkg::CMD_CLEAR: state_next = qph_pkg::ST_CLEAR;
                        default:            state_next = qph_pkg::ST_DONE;
                    endcase
                end
            end
            qph_pkg::ST_WALK:
            begin
                if (issue_idx_reg == active_reg)
                begin
                    state_next = qph_pkg::ST_DRAIN;
                end
            end
            qph_pkg::ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = qph_pkg::ST_DONE;
                end
            end
            qph_pkg::ST_READ:  state_next = qph_pkg::ST_RWAIT;
            qph_pkg::ST_RWAIT: state_next = qph_pkg::ST_DONE;
            qph_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_ADDR)
                begin
                    state_next = qph_pkg::ST_DONE;
                end
            end
            qph_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = qph_pkg::ST_IDLE;
                end
            end
            default: state_next = qph_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        entry_next     = entry_reg;
        pattern_next   = pattern_reg;
        rd_ok_next     = rd_ok_reg;
        obs_next       = obs_reg;
        active_next    = active_reg;
        issue_idx_next = issue_idx_reg;
        result_next    = result_reg;
        clr_idx_next   = clr_idx_reg;

        if (accept)
        begin
            entry_next     = to_qi(in_entry);
            pattern_next   = in_pattern;
            rd_ok_next     = entry_in_ok;
            obs_next       = in_obs[OBS_BITS-1:0];
            active_next    = (32'(num_quartets) > MAX_QUARTETS) ?
                             QC_W'(MAX_QUARTETS) : QC_W'(num_quartets);
            issue_idx_next = '0;
            result_next    = '0;
        end

        if (walk_issue)
        begin
            issue_idx_next = issue_idx_reg + QC_W'(1);
        end

        // stage 1: table word back, pattern formed, counter read issued
        s1_valid_next = walk_issue;
        s1_idx_next   = issue_idx_reg[QI_W-1:0];
        // stage 2: counter back, incremented or flagged
        s2_valid_next = s1_valid_reg;
        s2_addr_next  = {s1_idx_reg, pat_s1};

        if (s2_valid_reg && cnt_full)
        begin
            result_next.saturated = 1'b1;
        end

        if (state_reg == qph_pkg::ST_RWAIT)
        begin
            result_next.count_value = rd_ok_reg ? to_out(cnt_rdata) : '0;
        end

        if (clearing)
        begin
            clr_idx_next = (clr_idx_reg == LAST_ADDR) ? '0 : clr_idx_reg + CA_W'(1);
        end
    end

    always_comb
    begin
        in_ready  = (state_reg == qph_pkg::ST_IDLE);
        done      = (state_reg == qph_pkg::ST_DONE);
        result    = result_reg;

        tbl_we    = accept && (in_cmd == qph_pkg::CMD_LOAD) && entry_in_ok;
        tbl_waddr = to_qi(in_entry);
        tbl_wdata = in_quartet;
        tbl_raddr = issue_idx_reg[QI_W-1:0];

        cnt_raddr = (state_reg == qph_pkg::ST_READ) ? {entry_reg, pattern_reg}
                                                    : {s1_idx_reg, pat_s1};
        cnt_we    = clearing || (s2_valid_reg && !cnt_full);
        cnt_waddr = clearing ? clr_idx_reg : s2_addr_reg;
        cnt_wdata = clearing ? '0 : cnt_rdata + COUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qph_pkg::ST_INIT;
            active_reg    <= '0;
            issue_idx_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            issue_idx_reg <= issue_idx_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            clr_idx_reg   <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        pattern_reg <= pattern_next;
        rd_ok_reg   <= rd_ok_next;
        obs_reg     <= obs_next;
        s1_idx_reg  <= s1_idx_next;
        s2_addr_reg <= s2_addr_next;
        result_reg  <= result_next;
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qph_pkg::ST_IDLE) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("walk pipeline busy while idle");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qph_pkg::ST_WALK) |-> (issue_idx_reg <= active_reg))
        else $error("walk index past active quartets");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qph_pkg::ST_DONE && !out_free) |=>
        (state_reg == qph_pkg::ST_DONE && $stable(result_reg)))
        else $error("result lost before output slot free");

    a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qph_pkg::ST_INIT || state_reg == qph_pkg::ST_CLEAR)
        |-> (!s2_valid_reg && clr_idx_reg <= LAST_ADDR))
        else $error("counter update overlaps clear sweep");
`endif

endmodule

`default_nettype wire

/* rtl/quartet_pattern_histogram_core.sv */
`default_nettype none

// count: one quartet per cycle through the counter memory read-modify-write pipeline,
//   one word at a time
// clear: one counter a cycle; the next word can be taken in the cycle after the result
//   reaches the output register
// reset: control clears at once, then a sweep zeroes the counters with s_tready low;
//   config writes are taken throughout
module quartet_pattern_histogram_core #(
    parameter int MAX_QUARTETS = qph_pkg::MAX_QUARTETS_DEF,
    parameter int OBS_BITS     = qph_pkg::OBS_BITS_DEF,
    parameter int COUNT_BITS   = qph_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // apb config
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [qph_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [qph_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [qph_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // cmd, entry, pattern, idx_a, idx_b, idx_c, idx_d, obs_bits
    input  wire logic [qph_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // count_value, saturated, zero pad
    output logic      [qph_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int QI_W = (MAX_QUARTETS > 1) ? $clog2(MAX_QUARTETS) : 1;
    localparam int CA_W = QI_W + qph_pkg::PAT_W;

    logic [qph_pkg::NUMQ_W-1:0]      num_quartets_reg, num_quartets_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    qph_pkg::res_t                   out_res_reg, out_res_next;

    logic                            cfg_we;
    logic                            out_free;
    logic                            done;
    qph_pkg::res_t                   result;

    logic                            tbl_we;
    logic [QI_W-1:0]                 tbl_waddr;
    logic [qph_pkg::QUARTET_W-1:0]   tbl_wdata;
    logic [QI_W-1:0]                 tbl_raddr;
    logic [qph_pkg::QUARTET_W-1:0]   tbl_rdata;

    logic                            cnt_we;
    logic [CA_W-1:0]                 cnt_waddr;
    logic [COUNT_BITS-1:0]           cnt_wdata;
    logic [CA_W-1:0]                 cnt_raddr;
    logic [COUNT_BITS-1:0]           cnt_rdata;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        num_quartets_next = num_quartets_reg;
        if (cfg_we && (paddr[2:2] == qph_pkg::REG_NUM_QUARTETS))
        begin
            num_quartets_next = pwdata[qph_pkg::NUMQ_W-1:0];
        end
        prdata = '0;
        if (paddr[2:2] == qph_pkg::REG_NUM_QUARTETS)
        begin
            prdata = {{(qph_pkg::APB_DATA_W - qph_pkg::NUMQ_W){1'b0}}, num_quartets_reg};
        end
    end

    // output register: next word may be accepted while this one waits
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_res_next  = out_res_reg;
        if (done && out_free)
        begin
            m_tvalid_next = 1'b1;
            out_res_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_quartets_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            num_quartets_reg <= num_quartets_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(qph_pkg::OUT_TDATA_W - qph_pkg::CNT_OUT_W - 1){1'b0}},
                       out_res_reg.saturated, out_res_reg.count_value};

    qph_ctrl #(
        .MAX_QUARTETS (MAX_QUARTETS),
        .OBS_BITS     (OBS_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (qph_pkg::cmd_t'(s_tdata[1:0])),
        .in_entry     (s_tdata[7:2]),
        .in_pattern   (s_tdata[11:8]),
        .in_quartet   (s_tdata[39:12]),
        .in_obs       (s_tdata[103:40]),
        .num_quartets (num_quartets_reg),
        .out_free     (out_free),
        .done         (done),
        .result       (result),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .tbl_wdata    (tbl_wdata),
        .tbl_raddr    (tbl_raddr),
        .tbl_rdata    (tbl_rdata),
        .cnt_we       (cnt_we),
        .cnt_waddr    (cnt_waddr),
        .cnt_wdata    (cnt_wdata),
        .cnt_raddr    (cnt_raddr),
        .cnt_rdata    (cnt_rdata)
    );

    qph_ram #(
        .DEPTH (MAX_QUARTETS),
        .AW    (QI_W),
        .DW    (qph_pkg::QUARTET_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    qph_ram #(
        .DEPTH (MAX_QUARTETS * 16),
        .AW    (CA_W),
        .DW    (COUNT_BITS)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

endmodule

`default_nettype wire

/* tb/tb_quartet_pattern_histogram_core.sv */
`timescale 1ns / 1ps

module tb_quartet_pattern_histogram_core;

    localparam int MAX_Q  = qph_pkg::MAX_QUARTETS_DEF;
    localparam int OBS_N  = qph_pkg::OBS_BITS_DEF;
    localparam int CNT_W  = qph_pkg::COUNT_BITS_DEF;

    // first field in the lowest bits of tdata
    typedef struct packed {
        logic [qph_pkg::OBS_W-1:0]   obs_bits;
        logic [qph_pkg::IDX_W-1:0]   idx_d;
        logic [qph_pkg::IDX_W-1:0]   idx_c;
        logic [qph_pkg::IDX_W-1:0]   idx_b;
        logic [qph_pkg::IDX_W-1:0]   idx_a;
        logic [qph_pkg::PAT_W-1:0]   pattern;
        logic [qph_pkg::ENTRY_W-1:0] entry;
        qph_pkg::cmd_t               cmd;
    } command_word_t;

    typedef struct packed {
        logic [6:0]                    pad;
        logic                          saturated;
        logic [qph_pkg::CNT_OUT_W-1:0] count_value;
    } result_word_t;

    class quartet_count_model;
        logic [qph_pkg::IDX_W-1:0] quartets [MAX_Q][4];
        logic [CNT_W-1:0] counters [MAX_Q*16];
        logic [qph_pkg::NUMQ_W-1:0] quartet_count;
        result_word_t expected_results [$];

        function new();
            foreach (quartets[i, j])
                quartets[i][j] = '0;
            foreach (counters[i])
                counters[i] = '0;
            quartet_count = '0;
        endfunction

        function void apply_quartet_count(int value);
            quartet_count = qph_pkg::NUMQ_W'(value);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic pick_bit(logic [qph_pkg::IDX_W-1:0] raw,
                                logic [qph_pkg::OBS_W-1:0] obs);
            // sign bit set means the bit is absent
            if (raw[qph_pkg::IDX_W-1])
                return 1'b0;
            if (int'(raw[qph_pkg::IDX_W-2:0]) >= OBS_N)
                return 1'b0;
            return obs[raw[qph_pkg::IDX_W-2:0]];
        endfunction

        function void note_command(command_word_t w);
            result_word_t r;
            int active;
            int slot;
            logic [3:0] p;
            r = '0;
            case (w.cmd)
                qph_pkg::CMD_LOAD:
                begin
                    if (int'(w.entry) < MAX_Q)
                    begin
                        quartets[w.entry][0] = w.idx_a;
                        quartets[w.entry][1] = w.idx_b;
                        quartets[w.entry][2] = w.idx_c;
                        quartets[w.entry][3] = w.idx_d;
                    end
                end
                qph_pkg::CMD_COUNT:
                begin
                    active = (int'(quartet_count) > MAX_Q) ? MAX_Q : int'(quartet_count);
                    for (int s = 0; s < active; s++)
                    begin
                        p = {pick_bit(quartets[s][0], w.obs_bits),
                             pick_bit(quartets[s][1], w.obs_bits),
                             pick_bit(quartets[s][2], w.obs_bits),
                             pick_bit(quartets[s][3], w.obs_bits)};
                        slot = s * 16 + int'(p);
                        if (counters[slot] == {CNT_W{1'b1}})
                            r.saturated = 1'b1;
                        else
                            counters[slot] = counters[slot] + 1'b1;
                    end
                end
                qph_pkg::CMD_READ:
                begin
                    if (int'(w.entry) < MAX_Q)
                        r.count_value = qph_pkg::CNT_OUT_W'(
                            counters[int'(w.entry) * 16 + int'(w.pattern)]);
                end
                default:
                begin
                    foreach (counters[i])
                        counters[i] = '0;
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function bit check_result(result_word_t got, output string msg);
            result_word_t want;
            msg = "";
            if (expected_results.size() == 0)
            begin
                msg = $sformatf("result word %h with nothing expected", got);
                return 1'b0;
            end
            want = expected_results.pop_front();
            if (got.count_value !== want.count_value)
                msg = {msg, $sformatf(" count_value got %h want %h",
                                      got.count_value, want.count_value)};
            if (got.saturated !== want.saturated)
                msg = {msg, $sformatf(" saturated got %b want %b",
                                      got.saturated, want.saturated)};
            return msg == "";
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [qph_pkg::APB_ADDR_W-1:0] paddr;
    logic [qph_pkg::APB_DATA_W-1:0] pwdata;
    logic [qph_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [qph_pkg::IN_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [qph_pkg::OUT_TDATA_W-1:0] m_tdata;

    quartet_count_model histogram;
    int mismatches = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    quartet_pattern_histogram_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("quartet_pattern_histogram_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t:%s", $realtime, msg);
        mismatches++;
    endtask

    // receiver: stretches of always ready, random stalls and long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(2);
                stall_left = $urandom_range(300, 20);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1));
                default: m_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_monitor
        string msg;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (!histogram.check_result(result_word_t'(m_tdata), msg))
                report_mismatch(msg);
        end
    end

    function automatic command_word_t compose(qph_pkg::cmd_t c, int entry, int pattern,
                                              logic [qph_pkg::IDX_W-1:0] a,
                                              logic [qph_pkg::IDX_W-1:0] b,
                                              logic [qph_pkg::IDX_W-1:0] cc,
                                              logic [qph_pkg::IDX_W-1:0] d,
                                              logic [qph_pkg::OBS_W-1:0] obs);
        command_word_t w;
        w.cmd      = c;
        w.entry    = qph_pkg::ENTRY_W'(entry);
        w.pattern  = qph_pkg::PAT_W'(pattern);
        w.idx_a    = a;
        w.idx_b    = b;
        w.idx_c    = cc;
        w.idx_d    = d;
        w.obs_bits = obs;
        return w;
    endfunction

    function automatic logic [qph_pkg::IDX_W-1:0] random_index();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return qph_pkg::IDX_W'($urandom_range(63));
        else if (r < 93)
            return {qph_pkg::IDX_W{1'b1}};
        else
            return qph_pkg::IDX_W'($urandom_range(127, 64));
    endfunction

    function automatic logic [qph_pkg::OBS_W-1:0] random_obs();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return qph_pkg::OBS_W'(1) << $urandom_range(qph_pkg::OBS_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // reads stay inside the first span entries, which are known to be loaded;
    // most of them land on the hot entries that counts actually touch
    function automatic command_word_t random_op(int hot, int span);
        command_word_t w;
        int r;
        w = compose(qph_pkg::CMD_LOAD, $urandom_range(63), $urandom_range(15),
                    random_index(), random_index(), random_index(), random_index(),
                    random_obs());
        r = $urandom_range(99);
        if (r < 20)
            w.cmd = qph_pkg::CMD_LOAD;
        else if (r < 58)
            w.cmd = qph_pkg::CMD_COUNT;
        else if (r < 97)
        begin
            w.cmd = qph_pkg::CMD_READ;
            if (hot > 0 && $urandom_range(3) != 0)
                w.entry = qph_pkg::ENTRY_W'($urandom_range(hot - 1));
            else
                w.entry = qph_pkg::ENTRY_W'($urandom_range(span - 1));
        end
        else
            w.cmd = qph_pkg::CMD_CLEAR;
        return w;
    endfunction

    task automatic send(input command_word_t w);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(16, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        histogram.note_command(w);
    endtask

    // only with the block idle: no word offered and every result back
    task automatic set_quartet_count(input int value);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (histogram.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {qph_pkg::REG_NUM_QUARTETS, 2'b00};
        pwdata  <= qph_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        histogram.apply_quartet_count(value);
    endtask

    initial
    begin : stimulus
        int cfg [8];
        int hot;
        histogram = new();
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // no active quartets: counts change nothing
        set_quartet_count(0);
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, '1));
        send(compose(qph_pkg::CMD_LOAD, 0, 0, 7'h7f, 7'h40, 7'd63, 7'd0, '0));
        send(compose(qph_pkg::CMD_LOAD, 1, 0, 7'd63, 7'd62, 7'd1, 7'd0, '0));
        send(compose(qph_pkg::CMD_LOAD, 2, 0, 7'd31, 7'd32, 7'h7f, 7'd15, '0));
        send(compose(qph_pkg::CMD_LOAD, 3, 0, 7'd5, 7'h7f, 7'd42, 7'h7f, '0));
        send(compose(qph_pkg::CMD_LOAD, 63, 0, 7'd63, 7'd16, 7'h60, 7'd63, '0));
        send(compose(qph_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_READ, 63, 15, 0, 0, 0, 0, '0));

        set_quartet_count(4);
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, '1));
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0001));
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, 64'haaaa_aaaa_aaaa_aaaa));
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, 64'h5555_5555_5555_5555));
        send(compose(qph_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_READ, 0, 3, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_READ, 1, 15, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_READ, 1, 8, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_READ, 2, 5, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_READ, 1, 15, 0, 0, 0, 0, '0));
        send(compose(qph_pkg::CMD_COUNT, 0, 0, 0, 0, 0, 0, random_obs()));
        send(compose(qph_pkg::CMD_READ, 3, $urandom_range(15), 0, 0, 0, 0, '0));

        // fill the rest of the table, with traffic on the four live quartets
        for (int e = 4; e < MAX_Q - 1; e++)
        begin
            send(compose(qph_pkg::CMD_LOAD, e, $urandom_range(15), random_index(),
                         random_index(), random_index(), random_index(), random_obs()));
            if ($urandom_range(9) < 3)
                send(random_op(4, 4));
        end

        cfg = '{64, 127, 1, $urandom_range(2, 63), 0, $urandom_range(65, 126),
                $urandom_range(8, 40), 64};
        foreach (cfg[ph])
        begin
            set_quartet_count(cfg[ph]);
            hot = (cfg[ph] > MAX_Q) ? MAX_Q : cfg[ph];
            repeat (200) send(random_op(hot, MAX_Q));
        end

        s_tvalid <= 1'b0;
        while (histogram.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("quartet_pattern_histogram_core verification clean");
        else
            $display("quartet_pattern_histogram_core verification failed");
        $finish;
    end

endmodule
